// ===== rtl/core/rsl_pkg.sv =====
package rsl_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_UP_L   = 8'h4c;
	localparam logic [7:0] CH_UP_R   = 8'h52;
	localparam logic [7:0] CH_UP_U   = 8'h55;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [3:0] {
		CL_NUL,
		CL_SPACE,
		CL_CTRL_WS,
		CL_L_OR_U,
		CL_LOW_U,
		CL_R,
		CL_EIGHT,
		CL_QUOTE,
		CL_LPAREN,
		CL_RPAREN,
		CL_BSLASH,
		CL_OTHER
	} char_class_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LEAD,
		PH_AFTER_U,
		PH_WANT_R,
		PH_WANT_QUOTE,
		PH_DELIM,
		PH_BODY,
		PH_CLOSE
	} phase_t;

	typedef enum logic [1:0] {
		V_IDLE   = 2'd0,
		V_SCAN   = 2'd1,
		V_ACCEPT = 2'd2,
		V_REJECT = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] character;
		logic       start_req;
		logic       raw_allowed;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  character;
		char_class_t cls;
		logic        start_req;
		logic        raw_allowed;
	} mid_item_t;

	typedef struct packed {
		verdict_t   verdict;
		logic       in_token;
		logic [4:0] delimiter_count;
	} out_item_t;

endpackage

// ===== rtl/core/rsl_fifo.sv =====
module rsl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/rsl_front.sv =====
module rsl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rsl_pkg::in_item_t   item,
	output logic                full,
	output logic                mid_push,
	output rsl_pkg::mid_item_t  mid_item,
	input  logic                mid_full
);

	logic               valid_s1;
	rsl_pkg::mid_item_t data_s1;
	rsl_pkg::char_class_t cls;
	logic               advance;

	assign advance  = !valid_s1 || !mid_full;
	assign full     = !advance;
	assign mid_push = valid_s1;
	assign mid_item = data_s1;

	always_comb begin
		unique case (item.character)
			rsl_pkg::CH_NUL:    cls = rsl_pkg::CL_NUL;
			rsl_pkg::CH_SPACE:  cls = rsl_pkg::CL_SPACE;
			rsl_pkg::CH_TAB,
			rsl_pkg::CH_LF,
			rsl_pkg::CH_CR:     cls = rsl_pkg::CL_CTRL_WS;
			rsl_pkg::CH_UP_L,
			rsl_pkg::CH_UP_U:   cls = rsl_pkg::CL_L_OR_U;
			rsl_pkg::CH_LOW_U:  cls = rsl_pkg::CL_LOW_U;
			rsl_pkg::CH_UP_R:   cls = rsl_pkg::CL_R;
			rsl_pkg::CH_EIGHT:  cls = rsl_pkg::CL_EIGHT;
			rsl_pkg::CH_QUOTE:  cls = rsl_pkg::CL_QUOTE;
			rsl_pkg::CH_LPAREN: cls = rsl_pkg::CL_LPAREN;
			rsl_pkg::CH_RPAREN: cls = rsl_pkg::CL_RPAREN;
			rsl_pkg::CH_BSLASH: cls = rsl_pkg::CL_BSLASH;
			default:            cls = rsl_pkg::CL_OTHER;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push && advance) begin
			data_s1.character   <= item.character;
			data_s1.cls         <= cls;
			data_s1.start_req   <= item.start_req;
			data_s1.raw_allowed <= item.raw_allowed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

endmodule

// ===== rtl/core/rsl_back.sv =====
module rsl_back #(
	parameter int MAX_DELIM = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mid_empty,
	input  rsl_pkg::mid_item_t mid_item,
	output logic               mid_pop,
	input  logic               out_full,
	output logic               out_push,
	output rsl_pkg::out_item_t out_item
);

	localparam int LW = $clog2(MAX_DELIM + 1);
	localparam int IW = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

	rsl_pkg::phase_t phase_q;
	rsl_pkg::phase_t ph;
	rsl_pkg::phase_t phase_n;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   len_cur;
	logic [LW-1:0]   len_n;
	logic [LW-1:0]   mpos_q;
	logic [LW-1:0]   mpos_cur;
	logic [LW-1:0]   mpos_n;
	logic [7:0]      dstore_q [MAX_DELIM];
	logic [7:0]      rd_q;
	logic [IW-1:0]   rd_addr;
	logic            step;
	logic            wr_en;
	rsl_pkg::verdict_t verdict;
	logic            took;

	assign step    = !mid_empty && !out_full;
	assign mid_pop = step;
	assign out_push = step;

	assign ph       = mid_item.start_req ?
		(mid_item.raw_allowed ? rsl_pkg::PH_LEAD : rsl_pkg::PH_IDLE) : phase_q;
	assign len_cur  = mid_item.start_req ? '0 : len_q;
	assign mpos_cur = mid_item.start_req ? '0 : mpos_q;

	always_comb begin
		phase_n = ph;
		len_n   = len_cur;
		mpos_n  = mpos_cur;
		verdict = rsl_pkg::V_SCAN;
		took    = 1'b0;
		wr_en   = 1'b0;
		if (mid_item.start_req && !mid_item.raw_allowed) begin
			verdict = rsl_pkg::V_REJECT;
		end else begin
			unique case (ph)
				rsl_pkg::PH_IDLE: begin
					verdict = rsl_pkg::V_IDLE;
				end
				rsl_pkg::PH_LEAD: begin
					unique case (mid_item.cls)
						rsl_pkg::CL_SPACE, rsl_pkg::CL_CTRL_WS: begin
							took = 1'b0;
						end
						rsl_pkg::CL_L_OR_U: begin
							took    = 1'b1;
							phase_n = rsl_pkg::PH_WANT_R;
						end
						rsl_pkg::CL_LOW_U: begin
							took    = 1'b1;
							phase_n = rsl_pkg::PH_AFTER_U;
						end
						rsl_pkg::CL_R: begin
							took    = 1'b1;
							phase_n = rsl_pkg::PH_WANT_QUOTE;
						end
						default: begin
							verdict = rsl_pkg::V_REJECT;
							phase_n = rsl_pkg::PH_IDLE;
						end
					endcase
				end
				rsl_pkg::PH_AFTER_U: begin
					if (mid_item.cls == rsl_pkg::CL_EIGHT) begin
						took    = 1'b1;
						phase_n = rsl_pkg::PH_WANT_R;
					end else if (mid_item.cls == rsl_pkg::CL_R) begin
						took    = 1'b1;
						phase_n = rsl_pkg::PH_WANT_QUOTE;
					end else begin
						verdict = rsl_pkg::V_REJECT;
						phase_n = rsl_pkg::PH_IDLE;
					end
				end
				rsl_pkg::PH_WANT_R: begin
					if (mid_item.cls == rsl_pkg::CL_R) begin
						took    = 1'b1;
						phase_n = rsl_pkg::PH_WANT_QUOTE;
					end else begin
						verdict = rsl_pkg::V_REJECT;
						phase_n = rsl_pkg::PH_IDLE;
					end
				end
				rsl_pkg::PH_WANT_QUOTE: begin
					if (mid_item.cls == rsl_pkg::CL_QUOTE) begin
						took    = 1'b1;
						len_n   = '0;
						phase_n = rsl_pkg::PH_DELIM;
					end else begin
						verdict = rsl_pkg::V_REJECT;
						phase_n = rsl_pkg::PH_IDLE;
					end
				end
				rsl_pkg::PH_DELIM: begin
					if (mid_item.cls == rsl_pkg::CL_LPAREN) begin
						took    = 1'b1;
						phase_n = rsl_pkg::PH_BODY;
					end else if (mid_item.cls == rsl_pkg::CL_NUL ||
						mid_item.cls == rsl_pkg::CL_SPACE ||
						mid_item.cls == rsl_pkg::CL_BSLASH ||
						mid_item.cls == rsl_pkg::CL_RPAREN ||
						mid_item.cls == rsl_pkg::CL_QUOTE ||
						len_cur >= LW'(MAX_DELIM)) begin
						verdict = rsl_pkg::V_REJECT;
						phase_n = rsl_pkg::PH_IDLE;
					end else begin
						took  = 1'b1;
						wr_en = 1'b1;
						len_n = len_cur + 1'b1;
					end
				end
				rsl_pkg::PH_BODY, rsl_pkg::PH_CLOSE: begin
					if (ph == rsl_pkg::PH_CLOSE && mpos_cur < len_cur &&
						mid_item.character == rd_q) begin
						took   = 1'b1;
						mpos_n = mpos_cur + 1'b1;
					end else if (ph == rsl_pkg::PH_CLOSE && mpos_cur == len_cur &&
						mid_item.cls == rsl_pkg::CL_QUOTE) begin
						took    = 1'b1;
						verdict = rsl_pkg::V_ACCEPT;
						phase_n = rsl_pkg::PH_IDLE;
					end else if (mid_item.cls == rsl_pkg::CL_NUL) begin
						verdict = rsl_pkg::V_REJECT;
						phase_n = rsl_pkg::PH_IDLE;
					end else if (mid_item.cls == rsl_pkg::CL_RPAREN) begin
						took    = 1'b1;
						mpos_n  = '0;
						phase_n = rsl_pkg::PH_CLOSE;
					end else begin
						took    = 1'b1;
						phase_n = rsl_pkg::PH_BODY;
					end
				end
				default: begin
					verdict = rsl_pkg::V_IDLE;
					phase_n = rsl_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		out_item.verdict         = verdict;
		out_item.in_token        = took;
		out_item.delimiter_count = (verdict == rsl_pkg::V_IDLE) ? 5'd0 : 5'(len_n);
	end

	// prefetch the delimiter byte that the next step compares against
	assign rd_addr = step ? IW'(mpos_n) : IW'(mpos_q);

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			dstore_q[IW'(len_cur)] <= mid_item.character;
		end
		rd_q <= dstore_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rsl_pkg::PH_IDLE;
			len_q   <= '0;
			mpos_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			mpos_q  <= mpos_n;
		end
	end

endmodule

// ===== rtl/core/raw_string_literal_scanner.sv =====
// one result per character; the result of an item passes through the classify
// register and the request queue, then the scan step writes it into the result
// queue, from which it shows on the result ports
// throughput is one character per cycle while the result queue is not full
// reset clears the phase, delimiter length, match position and both queues
// the delimiter storage is not cleared; only written bytes are compared
module raw_string_literal_scanner #(
	parameter int MAX_DELIM = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rsl_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output rsl_pkg::out_item_t result
);

	rsl_pkg::mid_item_t front_item;
	rsl_pkg::mid_item_t back_item;
	rsl_pkg::out_item_t back_result;
	logic               front_push;
	logic               mid_full;
	logic               mid_empty;
	logic               mid_pop;
	logic               out_push;
	logic               out_full;

	rsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.mid_push (front_push),
		.mid_item (front_item),
		.mid_full (mid_full)
	);

	rsl_fifo #(
		.WIDTH ($bits(rsl_pkg::mid_item_t)),
		.DEPTH (rsl_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  (front_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (back_item),
		.empty  (mid_empty)
	);

	rsl_back #(
		.MAX_DELIM (MAX_DELIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (back_item),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (back_result)
	);

	rsl_fifo #(
		.WIDTH ($bits(rsl_pkg::out_item_t)),
		.DEPTH (rsl_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_result),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
